// ===== hdl/cau_pkg.sv =====
// Package for the complex arithmetic unit: operation and status codes,
// datapath widths and the item record that travels down the pipeline.
// Depends on nothing.
package cau_pkg;

  localparam int DATA_W = 16;
  localparam int VAL_W = 26;
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int REM_W = 41;
  localparam int DIV_BITS = 18;
  localparam int DSH_W = DEN_W + 1 + DIV_BITS - 1;
  localparam int DIV_STAGES = 6;
  localparam int DIV_STEPS_PER_STAGE = DIV_BITS / DIV_STAGES;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_CONJ = 4'd4,
    OP_INC  = 4'd5,
    OP_DEC  = 4'd6,
    OP_EQ   = 4'd7,
    OP_NE   = 4'd8,
    OP_LT   = 4'd9,
    OP_LE   = 4'd10,
    OP_GT   = 4'd11,
    OP_GE   = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef struct packed {
    logic                    is_div;
    logic                    flag;
    logic                    dz;
    logic                    neg_r;
    logic                    neg_i;
    logic                    ovf_r;
    logic                    ovf_i;
    logic [REM_W-1:0]        rem_r;
    logic [REM_W-1:0]        rem_i;
    logic [DSH_W-1:0]        dsh;
    logic [DIV_BITS-1:0]     q_r;
    logic [DIV_BITS-1:0]     q_i;
    logic signed [VAL_W-1:0] val_r;
    logic signed [VAL_W-1:0] val_i;
  } item_t;

endpackage

// ===== hdl/cau_front.sv =====
// Front end of the complex arithmetic unit: operand register, products,
// sums and divider setup in four register stages. Depends on cau_pkg.
module cau_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                in_valid,
  input  logic [3:0]                          op,
  input  logic signed [cau_pkg::DATA_W-1:0]   a_real,
  input  logic signed [cau_pkg::DATA_W-1:0]   a_imag,
  input  logic signed [cau_pkg::DATA_W-1:0]   b_real,
  input  logic signed [cau_pkg::DATA_W-1:0]   b_imag,
  output cau_pkg::item_t                      item,
  output logic                                item_valid
);

  logic [3:0] op_a;
  logic signed [cau_pkg::DATA_W-1:0] ar, ai, br, bi;
  logic valid_a;

  logic signed [31:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [17:0] s_r, s_i, s_r_next, s_i_next;
  logic flag_b, flag_b_next, mul_b, div_b, valid_b;

  logic signed [cau_pkg::VAL_W-1:0] val_r_c, val_i_c;
  logic signed [cau_pkg::NUM_W-1:0] n_r, n_i;
  logic [cau_pkg::DEN_W-1:0] den;
  logic flag_c, div_c, valid_c;

  logic signed [33:0] m_r, m_i;
  logic [cau_pkg::NUM_W-1:0] mag_r, mag_i;
  logic [cau_pkg::REM_W-1:0] big_r, big_i;
  logic [cau_pkg::DEN_W:0] dd;
  logic [cau_pkg::DSH_W:0] lim;
  cau_pkg::item_t item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      item_valid <= 1'b0;
    end else if (advance) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
      valid_c <= valid_b;
      item_valid <= valid_c;
    end
  end

  always_comb begin
    s_r_next = '0;
    s_i_next = '0;
    case (op_a)
      cau_pkg::OP_ADD: begin
        s_r_next = 18'(ar) + 18'(br);
        s_i_next = 18'(ai) + 18'(bi);
      end
      cau_pkg::OP_SUB: begin
        s_r_next = 18'(ar) - 18'(br);
        s_i_next = 18'(ai) - 18'(bi);
      end
      cau_pkg::OP_CONJ: begin
        s_r_next = 18'(ar);
        s_i_next = -18'(ai);
      end
      cau_pkg::OP_INC: begin
        s_r_next = 18'(ar) + 18'sd256;
        s_i_next = 18'(ai) + 18'sd256;
      end
      cau_pkg::OP_DEC: begin
        s_r_next = 18'(ar) - 18'sd256;
        s_i_next = 18'(ai) - 18'sd256;
      end
      default: begin
        s_r_next = '0;
        s_i_next = '0;
      end
    endcase
    case (op_a)
      cau_pkg::OP_EQ: flag_b_next = (ar == br) && (ai == bi);
      cau_pkg::OP_NE: flag_b_next = !((ar == br) && (ai == bi));
      cau_pkg::OP_LT: flag_b_next = (ar < br) && (ai < bi);
      cau_pkg::OP_LE: flag_b_next = (ar <= br) && (ai <= bi);
      cau_pkg::OP_GT: flag_b_next = (ar > br) && (ai > bi);
      cau_pkg::OP_GE: flag_b_next = (ar >= br) && (ai >= bi);
      default: flag_b_next = 1'b0;
    endcase
  end

  assign m_r = 34'(p_rr) - 34'(p_ii) + 34'sd128;
  assign m_i = 34'(p_ri) + 34'(p_ir) + 34'sd128;

  assign mag_r = n_r[cau_pkg::NUM_W-1] ? -n_r : n_r;
  assign mag_i = n_i[cau_pkg::NUM_W-1] ? -n_i : n_i;
  assign big_r = {mag_r[cau_pkg::DEN_W-1:0], 9'b0} + cau_pkg::REM_W'(den);
  assign big_i = {mag_i[cau_pkg::DEN_W-1:0], 9'b0} + cau_pkg::REM_W'(den);
  assign dd = {den, 1'b0};
  assign lim = {dd, 18'b0};

  always_comb begin
    item_next.is_div = div_c;
    item_next.flag = flag_c;
    item_next.dz = (den == '0);
    item_next.neg_r = n_r[cau_pkg::NUM_W-1];
    item_next.neg_i = n_i[cau_pkg::NUM_W-1];
    item_next.ovf_r = (cau_pkg::DSH_W+1)'(big_r) >= lim;
    item_next.ovf_i = (cau_pkg::DSH_W+1)'(big_i) >= lim;
    item_next.rem_r = big_r;
    item_next.rem_i = big_i;
    item_next.dsh = {dd, 17'b0};
    item_next.q_r = '0;
    item_next.q_i = '0;
    item_next.val_r = val_r_c;
    item_next.val_i = val_i_c;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op_a <= op;
      ar <= a_real;
      ai <= a_imag;
      br <= b_real;
      bi <= b_imag;

      p_rr <= ar * br;
      p_ii <= ai * bi;
      p_ri <= ar * bi;
      p_ir <= ai * br;
      p_bb <= br * br;
      p_cc <= bi * bi;
      s_r <= s_r_next;
      s_i <= s_i_next;
      flag_b <= flag_b_next;
      mul_b <= (op_a == cau_pkg::OP_MUL);
      div_b <= (op_a == cau_pkg::OP_DIV);

      val_r_c <= mul_b ? cau_pkg::VAL_W'(m_r >>> 8) : cau_pkg::VAL_W'(s_r);
      val_i_c <= mul_b ? cau_pkg::VAL_W'(m_i >>> 8) : cau_pkg::VAL_W'(s_i);
      n_r <= cau_pkg::NUM_W'(p_rr) + cau_pkg::NUM_W'(p_ii);
      n_i <= cau_pkg::NUM_W'(p_ir) - cau_pkg::NUM_W'(p_ri);
      den <= $unsigned(p_bb) + $unsigned(p_cc);
      flag_c <= flag_b;
      div_c <= div_b;

      item <= item_next;
    end
  end

endmodule

// ===== hdl/cau_div_stage.sv =====
// One stage of the restoring divider: three quotient bits for both parts.
// Depends on cau_pkg.
module cau_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  cau_pkg::item_t in_item,
  input  logic           in_item_valid,
  output cau_pkg::item_t item,
  output logic           item_valid
);

  cau_pkg::item_t item_next;

  always_comb begin
    item_next = in_item;
    for (int s = 0; s < cau_pkg::DIV_STEPS_PER_STAGE; s++) begin
      if (cau_pkg::DSH_W'(item_next.rem_r) >= item_next.dsh) begin
        item_next.rem_r = item_next.rem_r - cau_pkg::REM_W'(item_next.dsh);
        item_next.q_r = {item_next.q_r[cau_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        item_next.q_r = {item_next.q_r[cau_pkg::DIV_BITS-2:0], 1'b0};
      end
      if (cau_pkg::DSH_W'(item_next.rem_i) >= item_next.dsh) begin
        item_next.rem_i = item_next.rem_i - cau_pkg::REM_W'(item_next.dsh);
        item_next.q_i = {item_next.q_i[cau_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        item_next.q_i = {item_next.q_i[cau_pkg::DIV_BITS-2:0], 1'b0};
      end
      item_next.dsh = item_next.dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance) begin
      item_valid <= in_item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item <= item_next;
    end
  end

endmodule

// ===== hdl/cau_final.sv =====
// Output stage of the complex arithmetic unit: quotient sign and saturation,
// status and the output register. Depends on cau_pkg.
module cau_final (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  cau_pkg::item_t                    in_item,
  input  logic                              in_item_valid,
  output logic signed [cau_pkg::DATA_W-1:0] res_real,
  output logic signed [cau_pkg::DATA_W-1:0] res_imag,
  output logic                              cmp_flag,
  output logic [1:0]                        status,
  output logic                              out_valid
);

  logic signed [cau_pkg::DATA_W-1:0] r_next, i_next;
  logic sat_r, sat_i;

  function automatic logic signed [cau_pkg::DATA_W:0] quot_part(
    input logic neg,
    input logic ovf,
    input logic [cau_pkg::DIV_BITS-1:0] q
  );
    logic [cau_pkg::DIV_BITS-1:0] lim;
    logic [cau_pkg::DATA_W:0] res;
    lim = neg ? cau_pkg::DIV_BITS'(32768) : cau_pkg::DIV_BITS'(32767);
    if (ovf || q > lim) begin
      res = {1'b1, neg ? 16'h8000 : 16'h7fff};
    end else begin
      res = {1'b0, neg ? 16'(-q) : q[cau_pkg::DATA_W-1:0]};
    end
    return res;
  endfunction

  function automatic logic signed [cau_pkg::DATA_W:0] sat_part(
    input logic signed [cau_pkg::VAL_W-1:0] v
  );
    logic [cau_pkg::DATA_W:0] res;
    if (v > cau_pkg::VAL_W'(32767)) begin
      res = {1'b1, 16'h7fff};
    end else if (v < -cau_pkg::VAL_W'(32768)) begin
      res = {1'b1, 16'h8000};
    end else begin
      res = {1'b0, v[cau_pkg::DATA_W-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    logic [cau_pkg::DATA_W:0] pr, pi;
    if (in_item.is_div) begin
      pr = quot_part(in_item.neg_r, in_item.ovf_r, in_item.q_r);
      pi = quot_part(in_item.neg_i, in_item.ovf_i, in_item.q_i);
    end else begin
      pr = sat_part(in_item.val_r);
      pi = sat_part(in_item.val_i);
    end
    r_next = pr[cau_pkg::DATA_W-1:0];
    i_next = pi[cau_pkg::DATA_W-1:0];
    sat_r = pr[cau_pkg::DATA_W];
    sat_i = pi[cau_pkg::DATA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmp_flag <= in_item.flag;
      if (in_item.is_div && in_item.dz) begin
        res_real <= '0;
        res_imag <= '0;
        status <= cau_pkg::ST_DZ;
      end else begin
        res_real <= r_next;
        res_imag <= i_next;
        status <= (sat_r || sat_i) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front end, divider stages and
// output stage in one stalling pipeline. Depends on cau_pkg and its modules.
//
//   channel  signals                                  direction
//   in       in_valid in_ready op a_real a_imag       into the unit
//            b_real b_imag
//   out      out_valid out_ready res_real res_imag    out of the unit
//            cmp_flag status
//
// Every item passes through the four front stages, the six divider stages of
// three quotient bits each, and the output stage from its transfer in to its
// result. One item is taken in each cycle while the output is not stalled.
// Reset clears the valid bits of all stages. A stall on the output freezes
// the whole pipeline, and in_ready follows out_ready while a result waits.
module complex_arithmetic_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        op,
  input  logic signed [cau_pkg::DATA_W-1:0] a_real,
  input  logic signed [cau_pkg::DATA_W-1:0] a_imag,
  input  logic signed [cau_pkg::DATA_W-1:0] b_real,
  input  logic signed [cau_pkg::DATA_W-1:0] b_imag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cau_pkg::DATA_W-1:0] res_real,
  output logic signed [cau_pkg::DATA_W-1:0] res_imag,
  output logic                              cmp_flag,
  output logic [1:0]                        status
);

  logic advance;
  cau_pkg::item_t items [cau_pkg::DIV_STAGES+1];
  logic valids [cau_pkg::DIV_STAGES+1];

  assign advance = !out_valid || out_ready;
  assign in_ready = advance;

  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (in_valid),
    .op         (op),
    .a_real     (a_real),
    .a_imag     (a_imag),
    .b_real     (b_real),
    .b_imag     (b_imag),
    .item       (items[0]),
    .item_valid (valids[0])
  );

  for (genvar g = 0; g < cau_pkg::DIV_STAGES; g++) begin : g_div
    cau_div_stage u_stage (
      .clk           (clk),
      .rst           (rst),
      .advance       (advance),
      .in_item       (items[g]),
      .in_item_valid (valids[g]),
      .item          (items[g+1]),
      .item_valid    (valids[g+1])
    );
  end

  cau_final u_final (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_item       (items[cau_pkg::DIV_STAGES]),
    .in_item_valid (valids[cau_pkg::DIV_STAGES]),
    .res_real      (res_real),
    .res_imag      (res_imag),
    .cmp_flag      (cmp_flag),
    .status        (status),
    .out_valid     (out_valid)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cau_pkg::ST_DZ |-> res_real == '0 && res_imag == '0)
    else $error("Divide by zero result is not zero.");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmp_flag |-> status == cau_pkg::ST_OK && res_real == '0)
    else $error("Compare result carries data or status.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(valids[cau_pkg::DIV_STAGES]))
    else $error("Pipeline moved during a stall.");

endmodule
